>>> rtl/contour_cell_segments_core_defines.svh
// ----------------------------------------------------------------------------
// contour cell segments core - assertion macros
// shared assertion wrappers, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef CONTOUR_CELL_SEGMENTS_CORE_DEFINES_SVH
`define CONTOUR_CELL_SEGMENTS_CORE_DEFINES_SVH

// property that must hold on every clock outside reset
`define CCS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next
`define CCS_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/ccs_pkg.sv
// ----------------------------------------------------------------------------
// ccs_pkg
// shared widths, register indexes, types and divider step
// ----------------------------------------------------------------------------
package ccs_pkg;

  localparam int FRAC_BITS = 8;
  localparam int VAL_W     = 16;
  localparam int IDX_W     = 10;
  localparam int COORD_W   = 24;
  localparam int SCALE_W   = 16;
  localparam int QUO_W     = FRAC_BITS + 1;
  localparam int REM_W     = VAL_W + 1;
  localparam int G_W       = IDX_W + FRAC_BITS + 1;
  localparam int PROD_W    = G_W + SCALE_W;
  localparam int SUM_W     = PROD_W - FRAC_BITS + 2;
  localparam int STEPS_PER_STAGE = 3;
  localparam int DIV_STAGES = (QUO_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int QUEUE_DEPTH = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COORD_W;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DASH     = 3'd4;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic [SCALE_W-1:0]        scale_x;
    logic [SCALE_W-1:0]        scale_y;
    logic signed [VAL_W-1:0]   dash_threshold;
  } cfg_t;

  // one classified cell: per-side division operands and point order
  typedef struct packed {
    logic [3:0][VAL_W-1:0] num;
    logic [3:0][VAL_W-1:0] den;
    logic [3:0][1:0]       pt;
    logic                  two_seg;
    logic                  dashed;
    logic [IDX_W-1:0]      col;
    logic [IDX_W-1:0]      row;
  } job_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } div_t;

  // one restoring step: compare, subtract, shift remainder
  function automatic div_t div_step(input div_t s, input logic [VAL_W-1:0] d);
    div_t r;
    r = s;
    if (s.rem >= {1'b0, d}) begin
      r.rem = s.rem - {1'b0, d};
      r.quo = {s.quo[QUO_W-2:0], 1'b1};
    end else begin
      r.quo = {s.quo[QUO_W-2:0], 1'b0};
    end
    r.rem = {r.rem[REM_W-2:0], 1'b0};
    return r;
  endfunction

endpackage

>>> rtl/ccs_front.sv
// ----------------------------------------------------------------------------
// ccs_front
// classifies a cell: crossed sides, division operands, point order
// ----------------------------------------------------------------------------
module ccs_front (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [3:0][ccs_pkg::VAL_W-1:0]         corner,
  input  logic signed [ccs_pkg::VAL_W-1:0]       level,
  input  logic [ccs_pkg::IDX_W-1:0]              col,
  input  logic [ccs_pkg::IDX_W-1:0]              row,
  input  logic signed [ccs_pkg::VAL_W-1:0]       dash_threshold,
  output logic                                   job_valid,
  input  logic                                   job_ready,
  output ccs_pkg::job_t                          job
);

  function automatic logic [ccs_pkg::VAL_W-1:0] abs_diff(
    input logic signed [ccs_pkg::VAL_W-1:0] a,
    input logic signed [ccs_pkg::VAL_W-1:0] b);
    logic signed [ccs_pkg::VAL_W:0] d;
    d = {a[ccs_pkg::VAL_W-1], a} - {b[ccs_pkg::VAL_W-1], b};
    if (d < 0) d = -d;
    return d[ccs_pkg::VAL_W-1:0];
  endfunction

  logic signed [ccs_pkg::VAL_W-1:0] c [4];
  logic [3:0]             ge;
  logic [3:0]             crossing;
  logic signed [ccs_pkg::VAL_W-1:0] mx;
  logic [1:0]             imax;
  logic [1:0]             lo_side;
  logic [1:0]             hi_side;
  logic signed [ccs_pkg::VAL_W+1:0] sum;
  logic signed [ccs_pkg::VAL_W+1:0] lev4;
  ccs_pkg::job_t          job_next;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      c[j]  = corner[j];
      ge[j] = level >= c[j];
    end
    for (int s = 0; s < 4; s++) crossing[s] = ge[s] ^ ge[(s + 1) % 4];

    mx   = c[0];
    imax = 2'd0;
    for (int j = 1; j < 4; j++) begin
      if (c[j] > mx) begin
        mx   = c[j];
        imax = 2'(j);
      end
    end

    lo_side = 2'd0;
    for (int s = 3; s >= 0; s--) if (crossing[s]) lo_side = 2'(s);
    hi_side = 2'd0;
    for (int s = 0; s < 4; s++) if (crossing[s]) hi_side = 2'(s);

    sum = 18'(c[0]) + 18'(c[1]) + 18'(c[2]) + 18'(c[3]);
    lev4 = {level, 2'b00};

    job_next.num[0] = abs_diff(level, c[0]);
    job_next.den[0] = abs_diff(c[1], c[0]);
    job_next.num[1] = abs_diff(level, c[1]);
    job_next.den[1] = abs_diff(c[2], c[1]);
    job_next.num[2] = abs_diff(level, c[3]);
    job_next.den[2] = abs_diff(c[2], c[3]);
    job_next.num[3] = abs_diff(level, c[0]);
    job_next.den[3] = abs_diff(c[3], c[0]);

    job_next.two_seg = &crossing;
    if (&crossing) begin
      // saddle: walk back from the first maximum corner
      job_next.pt[0] = imax;
      job_next.pt[1] = imax - 2'd1;
      job_next.pt[2] = imax - 2'd2;
      job_next.pt[3] = imax - 2'd3;
      if (lev4 <= sum) begin
        job_next.pt[1] = imax - 2'd3;
        job_next.pt[3] = imax - 2'd1;
      end
    end else begin
      job_next.pt[0] = lo_side;
      job_next.pt[1] = hi_side;
      job_next.pt[2] = 2'd0;
      job_next.pt[3] = 2'd0;
    end
    job_next.dashed = level < dash_threshold;
    job_next.col    = col;
    job_next.row    = row;
  end

  assign in_ready = !job_valid || job_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      job_valid <= |crossing;
    end else if (job_ready) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) job <= job_next;
  end

endmodule

>>> rtl/ccs_fifo.sv
// ----------------------------------------------------------------------------
// ccs_fifo
// short job queue between classifier and datapath
// ----------------------------------------------------------------------------
module ccs_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  ccs_pkg::job_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output ccs_pkg::job_t rd_data
);

  localparam int PTR_W = $clog2(ccs_pkg::QUEUE_DEPTH);

  ccs_pkg::job_t      mem [ccs_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W:0]     count;
  logic               push;
  logic               pop;

  assign wr_ready = count != (PTR_W+1)'(ccs_pkg::QUEUE_DEPTH);
  assign rd_valid = count != '0;
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_data;
  end

endmodule

>>> rtl/ccs_back.sv
// ----------------------------------------------------------------------------
// ccs_back
// divides, places, scales and serialises the segments of one cell
// ----------------------------------------------------------------------------
module ccs_back (
  input  logic                                    clk,
  input  logic                                    rst,
  input  ccs_pkg::cfg_t                           cfg,
  input  logic                                    job_valid,
  output logic                                    job_ready,
  input  ccs_pkg::job_t                           job,
  output logic                                    seg_valid,
  input  logic                                    seg_ready,
  output logic signed [ccs_pkg::COORD_W-1:0]      start_x,
  output logic signed [ccs_pkg::COORD_W-1:0]      start_y,
  output logic signed [ccs_pkg::COORD_W-1:0]      end_x,
  output logic signed [ccs_pkg::COORD_W-1:0]      end_y,
  output logic                                    dashed,
  output logic                                    last_segment
);

  localparam int G_W    = ccs_pkg::G_W;
  localparam int PROD_W = ccs_pkg::PROD_W;
  localparam int SUM_W  = ccs_pkg::SUM_W;
  localparam int CW     = ccs_pkg::COORD_W;
  localparam int NST    = ccs_pkg::DIV_STAGES;

  typedef struct packed {
    logic [3:0][1:0]          pt;
    logic                     two_seg;
    logic                     dashed;
    logic [ccs_pkg::IDX_W-1:0] col;
    logic [ccs_pkg::IDX_W-1:0] row;
  } ctl_t;

  typedef struct packed {
    ccs_pkg::div_t [3:0]             lane;
    logic [3:0][ccs_pkg::VAL_W-1:0]  den;
    ctl_t                            ctl;
  } dstage_t;

  function automatic logic signed [CW-1:0] saturate(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'({1'b0, {(CW-1){1'b1}}});
    lo = -hi - SUM_W'(1);
    if (v > hi) return {1'b0, {(CW-1){1'b1}}};
    if (v < lo) return {1'b1, {(CW-1){1'b0}}};
    return v[CW-1:0];
  endfunction

  function automatic logic signed [CW-1:0] to_screen(
    input logic signed [CW-1:0] origin, input logic [PROD_W-1:0] prod);
    logic [PROD_W-1:0]       rnd;
    logic signed [SUM_W-1:0] v;
    rnd = prod + (PROD_W'(1) << (ccs_pkg::FRAC_BITS - 1));
    v = {{(SUM_W-CW){origin[CW-1]}}, origin}
      + $signed({2'b00, rnd[PROD_W-1:ccs_pkg::FRAC_BITS]});
    return saturate(v);
  endfunction

  logic stall;
  logic adv;

  // divider stages
  dstage_t d_in;
  dstage_t d_next [NST];
  dstage_t d_reg  [NST];
  logic    d_valid [NST];

  // placement stage
  logic [3:0][G_W-1:0] gx;
  logic [3:0][G_W-1:0] gy;
  logic [3:0][G_W-1:0] p_x;
  logic [3:0][G_W-1:0] p_y;
  logic                p_two;
  logic                p_dashed;
  logic                p_valid;

  // multiply stage
  logic [3:0][PROD_W-1:0] m_x;
  logic [3:0][PROD_W-1:0] m_y;
  logic                   m_two;
  logic                   m_dashed;
  logic                   m_valid;

  // result register
  logic signed [3:0][CW-1:0] f_x;
  logic signed [3:0][CW-1:0] f_y;
  logic                      f_two;
  logic                      f_dashed;
  logic                      f_valid;
  logic                      seg_idx;

  logic [G_W-1:0] cbase;
  logic [G_W-1:0] rbase;
  logic [G_W-1:0] one;
  ccs_pkg::div_t  s;

  assign stall     = f_valid && !(seg_ready && last_segment);
  assign adv       = !stall;
  assign job_ready = adv;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      d_in.lane[l].rem = {1'b0, job.num[l]};
      d_in.lane[l].quo = '0;
    end
    d_in.den         = job.den;
    d_in.ctl.pt      = job.pt;
    d_in.ctl.two_seg = job.two_seg;
    d_in.ctl.dashed  = job.dashed;
    d_in.ctl.col     = job.col;
    d_in.ctl.row     = job.row;
    for (int st = 0; st < NST; st++) begin
      d_next[st] = (st == 0) ? d_in : d_reg[(st == 0) ? 0 : st - 1];
      for (int l = 0; l < 4; l++) begin
        s = d_next[st].lane[l];
        for (int k = 0; k < ccs_pkg::STEPS_PER_STAGE; k++) begin
          if (st * ccs_pkg::STEPS_PER_STAGE + k < ccs_pkg::QUO_W)
            s = ccs_pkg::div_step(s, d_next[st].den[l]);
        end
        d_next[st].lane[l] = s;
      end
    end
  end

  always_comb begin
    one   = G_W'(1) << ccs_pkg::FRAC_BITS;
    cbase = G_W'(d_reg[NST-1].ctl.col) << ccs_pkg::FRAC_BITS;
    rbase = G_W'(d_reg[NST-1].ctl.row) << ccs_pkg::FRAC_BITS;
    gx[0] = cbase + G_W'(d_reg[NST-1].lane[0].quo);
    gy[0] = rbase;
    gx[1] = cbase + one;
    gy[1] = rbase + G_W'(d_reg[NST-1].lane[1].quo);
    gx[2] = cbase + G_W'(d_reg[NST-1].lane[2].quo);
    gy[2] = rbase + one;
    gx[3] = cbase;
    gy[3] = rbase + G_W'(d_reg[NST-1].lane[3].quo);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int st = 0; st < NST; st++) d_valid[st] <= 1'b0;
      p_valid <= 1'b0;
      m_valid <= 1'b0;
      f_valid <= 1'b0;
    end else if (adv) begin
      for (int st = 0; st < NST; st++)
        d_valid[st] <= (st == 0) ? job_valid : d_valid[(st == 0) ? 0 : st - 1];
      p_valid <= d_valid[NST-1];
      m_valid <= p_valid;
      f_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int st = 0; st < NST; st++) d_reg[st] <= d_next[st];
      for (int k = 0; k < 4; k++) begin
        p_x[k] <= gx[d_reg[NST-1].ctl.pt[k]];
        p_y[k] <= gy[d_reg[NST-1].ctl.pt[k]];
        m_x[k] <= PROD_W'(p_x[k]) * PROD_W'(cfg.scale_x);
        m_y[k] <= PROD_W'(p_y[k]) * PROD_W'(cfg.scale_y);
        f_x[k] <= to_screen(cfg.origin_x, m_x[k]);
        f_y[k] <= to_screen(cfg.origin_y, m_y[k]);
      end
      p_two    <= d_reg[NST-1].ctl.two_seg;
      p_dashed <= d_reg[NST-1].ctl.dashed;
      m_two    <= p_two;
      m_dashed <= p_dashed;
      f_two    <= m_two;
      f_dashed <= m_dashed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_idx <= 1'b0;
    end else if (seg_valid && seg_ready) begin
      seg_idx <= !last_segment;
    end
  end

  assign seg_valid    = f_valid;
  assign start_x      = seg_idx ? f_x[2] : f_x[0];
  assign start_y      = seg_idx ? f_y[2] : f_y[0];
  assign end_x        = seg_idx ? f_x[3] : f_x[1];
  assign end_y        = seg_idx ? f_y[3] : f_y[1];
  assign dashed       = f_dashed;
  assign last_segment = !f_two || seg_idx;

endmodule

>>> rtl/contour_cell_segments_core.sv
// ----------------------------------------------------------------------------
// contour_cell_segments_core
// marching-squares segments of one grid cell, scaled to screen coordinates
// ----------------------------------------------------------------------------
// channel   dir  width  content
// s_*       in   104    one cell and one contour level
// m_*       out  96+1+1 one segment, dashed flag, last of the cell
// cfg_*     in   3+24   register index and write data
//
// cells giving one segment pass at one word per cycle while the output is not
// stalled; a saddle cell gives two segment words, so the output port sets the rate
// the path from input to first segment runs through classifier, queue,
// three divider stages, placement, multiply, screen register
// rst is synchronous and empties classifier, queue and datapath
// a stalled output freezes the datapath; while there is room, the four-word queue and the
// classifier register keep accepting input meanwhile
// ----------------------------------------------------------------------------
module contour_cell_segments_core (
  input  logic                                 clk,
  input  logic                                 rst,
  // corner_top_left, corner_top_right, corner_bottom_right,
  // corner_bottom_left, contour_level, cell_col, cell_row, zero pad
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [103:0]                         s_tdata,
  // start_x, start_y, end_x, end_y
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [95:0]                          m_tdata,
  // dashed
  output logic                                 m_tuser,
  // last_segment
  output logic                                 m_tlast,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ccs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ccs_pkg::CFG_DATA_W-1:0]       cfg_data
);

  ccs_pkg::cfg_t cfg;

  // front to queue, queue to back
  logic          f_valid;
  logic          f_ready;
  ccs_pkg::job_t f_job;
  logic          q_valid;
  logic          q_ready;
  ccs_pkg::job_t q_job;

  logic [3:0][ccs_pkg::VAL_W-1:0]        corner;
  logic signed [ccs_pkg::COORD_W-1:0]    start_x;
  logic signed [ccs_pkg::COORD_W-1:0]    start_y;
  logic signed [ccs_pkg::COORD_W-1:0]    end_x;
  logic signed [ccs_pkg::COORD_W-1:0]    end_y;

  // configuration registers, to be written only while idle; the block does not enforce this
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x       <= '0;
      cfg.origin_y       <= '0;
      cfg.scale_x        <= ccs_pkg::SCALE_W'(256);
      cfg.scale_y        <= ccs_pkg::SCALE_W'(256);
      cfg.dash_threshold <= {1'b1, {(ccs_pkg::VAL_W-1){1'b0}}};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ccs_pkg::REG_ORIGIN_X: cfg.origin_x <= cfg_data;
        ccs_pkg::REG_ORIGIN_Y: cfg.origin_y <= cfg_data;
        ccs_pkg::REG_SCALE_X:  cfg.scale_x  <= cfg_data[ccs_pkg::SCALE_W-1:0];
        ccs_pkg::REG_SCALE_Y:  cfg.scale_y  <= cfg_data[ccs_pkg::SCALE_W-1:0];
        ccs_pkg::REG_DASH:     cfg.dash_threshold <= cfg_data[ccs_pkg::VAL_W-1:0];
        default: ;
      endcase
    end
  end

  // corners walked clockwise from top left
  assign corner[0] = s_tdata[15:0];
  assign corner[1] = s_tdata[31:16];
  assign corner[2] = s_tdata[47:32];
  assign corner[3] = s_tdata[63:48];

  ccs_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .corner         (corner),
    .level          (s_tdata[79:64]),
    .col            (s_tdata[89:80]),
    .row            (s_tdata[99:90]),
    .dash_threshold (cfg.dash_threshold),
    .job_valid      (f_valid),
    .job_ready      (f_ready),
    .job            (f_job)
  );

  ccs_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_job),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_job)
  );

  ccs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .job_valid    (q_valid),
    .job_ready    (q_ready),
    .job          (q_job),
    .seg_valid    (m_tvalid),
    .seg_ready    (m_tready),
    .start_x      (start_x),
    .start_y      (start_y),
    .end_x        (end_x),
    .end_y        (end_y),
    .dashed       (m_tuser),
    .last_segment (m_tlast)
  );

  assign m_tdata = {end_y, end_x, start_y, start_x};

endmodule

>>> rtl/ccs_checker.sv
// ----------------------------------------------------------------------------
// ccs_checker
// port-level checks on the segment stream, bound to the core
// ----------------------------------------------------------------------------
`include "contour_cell_segments_core_defines.svh"

module ccs_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [95:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  // stalled word holds
  `CCS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled segment word changed")

  // a saddle's first segment is followed at once by its last, same dash flag
  `CCS_ASSERT_NEXT(a_pair, m_tvalid && m_tready && !m_tlast, m_tvalid && m_tlast && $stable(m_tuser), "second segment of a saddle missing")

  // configuration is never back-pressured
  `CCS_ASSERT(a_cfg_ready, !cfg_valid || cfg_ready, "configuration write refused")

endmodule

bind contour_cell_segments_core ccs_checker u_ccs_checker (.*);

>>> verif/contour_cell_segments_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// contour_cell_segments_core_test
// drives cells and contour levels into the core and checks every segment
// against a cycle-free predictor held in a small scoreboard
// ----------------------------------------------------------------------------
// the predictor classifies each cell, places the side crossings by linear
// interpolation and scales them to screen coordinates with the current
// register copy; segments are compared field by field in arrival order
// ----------------------------------------------------------------------------
module contour_cell_segments_core_test;

  // one expected segment
  typedef struct {
    logic signed [23:0] sx, sy, ex, ey;
    logic               dashed;
    logic               last;
  } segment_t;

  // one cell and level, as sent
  typedef struct {
    logic signed [15:0] crn [4];
    logic signed [15:0] level;
    logic [9:0]         col, row;
  } cell_t;

  class segment_board;
    segment_t        pending[$];
    int              errors;
    int              seen;
    int              saddles;
    longint          org_x, org_y, scl_x, scl_y, dash;

    function new();
      errors = 0; seen = 0; saddles = 0;
      org_x = 0; org_y = 0; scl_x = 256; scl_y = 256; dash = -32768;
    endfunction

    function void write_reg(logic [ccs_pkg::CFG_IDX_W-1:0] idx, logic [23:0] v);
      case (idx)
        ccs_pkg::REG_ORIGIN_X: org_x = longint'(signed'(v));
        ccs_pkg::REG_ORIGIN_Y: org_y = longint'(signed'(v));
        ccs_pkg::REG_SCALE_X:  scl_x = longint'(v[15:0]);
        ccs_pkg::REG_SCALE_Y:  scl_y = longint'(v[15:0]);
        ccs_pkg::REG_DASH:     dash  = longint'(signed'(v[15:0]));
        default: ;
      endcase
    endfunction

    function longint frac(longint lev, longint a, longint b);
      longint n, d;
      n = lev - a; d = b - a;
      if (n < 0) n = -n;
      if (d < 0) d = -d;
      if (d == 0) return 0;
      return (n * 256) / d;
    endfunction

    function logic [23:0] screen(longint o, longint g, longint s);
      longint v;
      v = o + ((g * s + 128) >>> 8);
      if (v > 8388607) v = 8388607;
      if (v < -8388608) v = -8388608;
      return v[23:0];
    endfunction

    function bit crossed(longint lev, longint a, longint b);
      return (lev >= a && lev < b) || (lev < a && lev >= b);
    endfunction

    // work out the segments of one accepted cell
    function void note_cell(cell_t c);
      longint v[5], lev, mx, mn, gx[4], gy[4], px[4], py[4], t, col, row;
      int     imax, ns, idx;
      logic   dsh;
      segment_t s;
      for (int j = 0; j < 4; j++) v[j] = c.crn[j];
      v[4] = v[0];
      lev = c.level; col = c.col; row = c.row;
      mx = v[0]; mn = v[0]; imax = 1;
      for (int j = 1; j < 4; j++) begin
        if (v[j] > mx) begin
          mx = v[j]; imax = j + 1;
        end else if (v[j] < mn) mn = v[j];
      end
      if (lev > mx || lev < mn) return;
      dsh = lev < dash;
      ns = 0;
      if (crossed(lev, v[0], v[1])) begin
        gx[ns] = col * 256 + frac(lev, v[0], v[1]); gy[ns] = row * 256; ns++;
      end
      if (crossed(lev, v[1], v[2])) begin
        gx[ns] = (col + 1) * 256; gy[ns] = row * 256 + frac(lev, v[1], v[2]); ns++;
      end
      if (crossed(lev, v[2], v[3])) begin
        gx[ns] = col * 256 + frac(lev, v[3], v[2]); gy[ns] = (row + 1) * 256; ns++;
      end
      if (crossed(lev, v[3], v[4])) begin
        gx[ns] = col * 256; gy[ns] = row * 256 + frac(lev, v[4], v[3]); ns++;
      end
      if (ns == 2) begin
        for (int k = 0; k < 2; k++) begin
          px[k] = gx[k]; py[k] = gy[k];
        end
      end else if (ns == 4) begin
        saddles++;
        idx = imax;
        for (int k = 0; k < 4; k++) begin
          px[k] = gx[idx-1]; py[k] = gy[idx-1];
          idx = (idx == 1) ? 4 : idx - 1;
        end
        // swap the pairing when the level sits at or under the corner mean
        if (4 * lev <= v[0] + v[1] + v[2] + v[3]) begin
          t = px[3]; px[3] = px[1]; px[1] = t;
          t = py[3]; py[3] = py[1]; py[1] = t;
        end
      end else return;
      for (int k = 0; k < ns / 2; k++) begin
        s.sx = screen(org_x, px[2*k], scl_x);
        s.sy = screen(org_y, py[2*k], scl_y);
        s.ex = screen(org_x, px[2*k+1], scl_x);
        s.ey = screen(org_y, py[2*k+1], scl_y);
        s.dashed = dsh;
        s.last = (k == ns / 2 - 1);
        pending.push_back(s);
      end
    endfunction

    task report(string what, longint got, longint want);
      errors++;
      $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    endtask

    task check_segment(logic [95:0] d, logic dashed, logic last);
      segment_t w;
      seen++;
      if (pending.size() == 0) begin
        report("unexpected segment", d[23:0], 0);
        return;
      end
      w = pending.pop_front();
      if (d[23:0]  !== w.sx) report("start_x", d[23:0], w.sx);
      if (d[47:24] !== w.sy) report("start_y", d[47:24], w.sy);
      if (d[71:48] !== w.ex) report("end_x", d[71:48], w.ex);
      if (d[95:72] !== w.ey) report("end_y", d[95:72], w.ey);
      if (dashed !== w.dashed) report("dashed", dashed, w.dashed);
      if (last !== w.last) report("last_segment", last, w.last);
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0, s_tready;
  logic [103:0]       s_tdata = '0;
  logic               m_tvalid, m_tready = 1'b0;
  logic [95:0]        m_tdata;
  logic               m_tuser, m_tlast;
  logic               cfg_valid = 1'b0, cfg_ready;
  logic [ccs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ccs_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  segment_board board = new();
  int  send_idle_pct = 0;   // percent of cycles the sender holds back
  int  recv_idle_pct = 0;   // percent of cycles the receiver stalls
  int  hold_off = 0;        // cycles of forced receiver stall left
  int  cycles = 0;
  int  cells_sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  contour_cell_segments_core i_dut (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  // watchdog: far above the slowest legal run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("timeout with %0d segments outstanding", board.pending.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver: random stall plus the long hold-off
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      board.check_segment(m_tdata, m_tuser, m_tlast);
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // send one cell word, idling at random before it; valid stays up after
  // acceptance so that words can follow back to back
  task send_cell(cell_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata <= {16'h0, c.row, c.col, c.level, c.crn[3], c.crn[2], c.crn[1], c.crn[0]};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_cell(c);
    cells_sent++;
  endtask

  task write_reg(logic [ccs_pkg::CFG_IDX_W-1:0] idx, logic [23:0] v);
    cfg_index <= idx;
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    board.write_reg(idx, v);
    @(posedge clk);
  endtask

  // drop valid, wait for every segment and let the pipeline empty out
  task drain();
    s_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function cell_t make_cell(int a, int b, int c, int d, int lev, int col, int row);
    cell_t x;
    x.crn[0] = 16'(a); x.crn[1] = 16'(b); x.crn[2] = 16'(c); x.crn[3] = 16'(d);
    x.level = 16'(lev); x.col = 10'(col); x.row = 10'(row);
    return x;
  endfunction

  // random cell: mostly level within corner range, sometimes saddles or noise
  function cell_t random_cell();
    cell_t x;
    int lo, hi, m;
    m = $urandom_range(9);
    for (int j = 0; j < 4; j++) begin
      if (m < 3) x.crn[j] = 16'($urandom_range(40) - 20);
      else x.crn[j] = 16'($urandom);
    end
    if (m == 4) begin
      // saddle shape: diagonal corners high
      x.crn[0] = 16'($urandom_range(30000, 1000));
      x.crn[2] = 16'($urandom_range(30000, 1000));
      x.crn[1] = 16'(-$urandom_range(30000, 1000));
      x.crn[3] = 16'(-$urandom_range(30000, 1000));
    end
    lo = x.crn[0]; hi = x.crn[0];
    for (int j = 1; j < 4; j++) begin
      if (x.crn[j] < lo) lo = x.crn[j];
      if (x.crn[j] > hi) hi = x.crn[j];
    end
    if (m == 9) x.level = 16'($urandom);
    else if (m == 8) x.level = x.crn[$urandom_range(3)];
    else x.level = 16'(lo + $urandom_range(hi - lo));
    x.col = 10'($urandom); x.row = 10'($urandom);
    return x;
  endfunction

  task random_phase(int n, int s_pct, int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (n) send_cell(random_cell());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, plain crossings, saddles both ways, edge levels
    send_idle_pct = 0; recv_idle_pct = 0;
    send_cell(make_cell(0, 10, 10, 0, 5, 0, 0));
    send_cell(make_cell(10, 0, 0, 10, 5, 1023, 1023));
    send_cell(make_cell(10, -10, 10, -10, 1, 3, 4));   // saddle above mean
    send_cell(make_cell(10, -10, 10, -10, 0, 3, 4));   // saddle at mean, swapped
    send_cell(make_cell(-10, 10, -10, 10, -1, 5, 6));  // saddle from second corner
    send_cell(make_cell(32767, -32768, 32767, -32768, 0, 1023, 0));
    send_cell(make_cell(-32768, -32768, 32767, 32767, 32767, 0, 1023));
    send_cell(make_cell(-32768, -32768, 32767, 32767, -32768, 7, 7));
    send_cell(make_cell(5, 5, 5, 5, 5, 2, 2));         // at maximum, nothing crossed
    send_cell(make_cell(0, 1, 2, 3, 9, 2, 2));         // level above range
    send_cell(make_cell(0, 1, 2, 3, -9, 2, 2));        // level below range
    send_cell(make_cell(0, 0, 0, 1, 0, 8, 9));
    send_cell(make_cell(-1, -1, -1, -1, -1, 0, 0));
    drain();

    // extreme registers: largest and smallest origins and scales, saturating both ways
    write_reg(ccs_pkg::REG_ORIGIN_X, 24'h7fffff);
    write_reg(ccs_pkg::REG_ORIGIN_Y, 24'h800000);
    write_reg(ccs_pkg::REG_SCALE_X, 24'h00ffff);
    write_reg(ccs_pkg::REG_SCALE_Y, 24'h000000);
    write_reg(ccs_pkg::REG_DASH, 24'h007fff);
    send_cell(make_cell(0, 10, 10, 0, 5, 1023, 1023));
    send_cell(make_cell(10, -10, 10, -10, 2, 1023, 0));
    send_cell(make_cell(-32768, 32767, 32767, -32768, 32767, 0, 0));
    drain();
    write_reg(ccs_pkg::REG_ORIGIN_X, 24'h800000);
    write_reg(ccs_pkg::REG_ORIGIN_Y, 24'h7fffff);
    write_reg(ccs_pkg::REG_SCALE_Y, 24'h00ffff);
    write_reg(ccs_pkg::REG_DASH, 24'h008000);
    send_cell(make_cell(0, 10, 10, 0, 5, 1023, 1023));
    send_cell(make_cell(32767, -32768, 32767, -32768, -32768, 0, 1023));
    drain();

    // receiver holds off while the sender keeps offering cells
    write_reg(ccs_pkg::REG_ORIGIN_X, 24'h000000);
    write_reg(ccs_pkg::REG_ORIGIN_Y, 24'h000000);
    write_reg(ccs_pkg::REG_SCALE_X, 24'h000100);
    write_reg(ccs_pkg::REG_SCALE_Y, 24'h000100);
    write_reg(ccs_pkg::REG_DASH, 24'h000000);
    hold_off = 300;
    random_phase(30, 0, 0);
    drain();

    // random cells with random register settings per phase
    for (int p = 0; p < 3; p++) begin
      write_reg(ccs_pkg::REG_ORIGIN_X, 24'($urandom));
      write_reg(ccs_pkg::REG_ORIGIN_Y, 24'($urandom));
      write_reg(ccs_pkg::REG_SCALE_X, 24'($urandom_range(2048)));
      write_reg(ccs_pkg::REG_SCALE_Y, 24'($urandom));
      write_reg(ccs_pkg::REG_DASH, 24'($urandom));
      case (p)
        0: random_phase(200, 22, 66);
        1: random_phase(200, 66, 22);
        default: random_phase(200, 0, 0);
      endcase
      drain();
    end

    $display("sent %0d cells, checked %0d segments, %0d saddle cells",
             cells_sent, board.seen, board.saddles);
    if (board.errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
